>>> sv/pixel_format_convert_blend_macros.svh
// Assertion macros for the pixel format converter and blender.
// PFCB_ASSERT checks only while out of reset; PFCB_ASSERT_ALWAYS also checks during reset.
`ifndef PIXEL_FORMAT_CONVERT_BLEND_MACROS_SVH
`define PIXEL_FORMAT_CONVERT_BLEND_MACROS_SVH

`ifndef ASSERT_OFF
`define PFCB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PFCB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PFCB_ASSERT(label, prop, msg)
`define PFCB_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> sv/pfcb_pkg.sv
`timescale 1ns / 1ps

package pfcb_pkg;

    typedef enum logic [2:0] {
        FMT_NONE   = 3'd0,
        FMT_MONO   = 3'd1,
        FMT_RGB111 = 3'd2,
        FMT_RGB565 = 3'd3,
        FMT_RGB666 = 3'd4,
        FMT_RGB888 = 3'd5
    } fmt_t;

    typedef enum logic [1:0] {
        REG_FORE_FORMAT = 2'd0,
        REG_BACK_FORMAT = 2'd1,
        REG_OUT_FORMAT  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        DEP_0,
        DEP_1,
        DEP_5,
        DEP_6,
        DEP_8
    } depth_t;

    typedef enum logic [1:0] {
        BL_BACK,
        BL_FORE,
        BL_MIX
    } blend_sel_t;

    typedef logic [7:0] chan_t;
    typedef logic [2:0][7:0] pix_t;
    typedef logic [23:0] word_t;

    // rescale constants: (c * tmax) / smax == (c * K) >> SH, exact over the channel range
    localparam logic [29:0] K_5_6 = 30'd532791;
    localparam logic [29:0] K_5_8 = 30'd2156535;
    localparam logic [29:0] K_6_5 = 30'd515995;
    localparam logic [29:0] K_6_8 = 30'd4244475;
    localparam logic [29:0] K_8_5 = 30'd509919;
    localparam logic [29:0] K_8_6 = 30'd1036287;
    localparam int unsigned SH_FROM5 = 18;
    localparam int unsigned SH_FROM6 = 20;
    localparam int unsigned SH_FROM8 = 22;

    function automatic fmt_t norm_fmt(logic [2:0] code);
        fmt_t f;
        if (code > FMT_RGB888) begin
            f = FMT_NONE;
        end else begin
            f = fmt_t'(code);
        end
        return f;
    endfunction

    function automatic depth_t chan_depth(fmt_t f, logic [1:0] ch);
        depth_t d;
        case (f)
            FMT_MONO, FMT_RGB111: d = DEP_1;
            FMT_RGB565:           d = (ch == 2'd1) ? DEP_6 : DEP_5;
            FMT_RGB666:           d = DEP_6;
            FMT_RGB888:           d = DEP_8;
            default:              d = DEP_0;
        endcase
        return d;
    endfunction

    function automatic chan_t depth_max(depth_t d);
        chan_t m;
        case (d)
            DEP_1:   m = 8'h01;
            DEP_5:   m = 8'h1F;
            DEP_6:   m = 8'h3F;
            DEP_8:   m = 8'hFF;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic pix_t unpack_pix(word_t w, fmt_t f);
        pix_t p;
        p = '0;
        case (f)
            FMT_MONO: begin
                p[0] = {7'd0, w[0]};
                p[1] = {7'd0, w[0]};
                p[2] = {7'd0, w[0]};
            end
            FMT_RGB111: begin
                p[0] = {7'd0, w[2]};
                p[1] = {7'd0, w[1]};
                p[2] = {7'd0, w[0]};
            end
            FMT_RGB565: begin
                p[0] = {3'd0, w[15:11]};
                p[1] = {2'd0, w[10:5]};
                p[2] = {3'd0, w[4:0]};
            end
            FMT_RGB666: begin
                p[0] = {2'd0, w[17:12]};
                p[1] = {2'd0, w[11:6]};
                p[2] = {2'd0, w[5:0]};
            end
            FMT_RGB888: begin
                p[0] = w[23:16];
                p[1] = w[15:8];
                p[2] = w[7:0];
            end
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic word_t pack_pix(pix_t p, fmt_t f);
        word_t w;
        case (f)
            FMT_MONO:   w = {23'd0, |{p[0], p[1], p[2]}};
            FMT_RGB111: w = {21'd0, p[0][0], p[1][0], p[2][0]};
            FMT_RGB565: w = {8'd0, p[0][4:0], p[1][5:0], p[2][4:0]};
            FMT_RGB666: w = {6'd0, p[0][5:0], p[1][5:0], p[2][5:0]};
            FMT_RGB888: w = {p[0], p[1], p[2]};
            default:    w = '0;
        endcase
        return w;
    endfunction

    function automatic chan_t rescale_chan(chan_t c, depth_t src, depth_t dst);
        chan_t       cm;
        logic [29:0] prod;
        chan_t       res;
        cm   = c & depth_max(src);
        prod = '0;
        res  = '0;
        if (src == DEP_0 || dst == DEP_0) begin
            res = '0;
        end else if (src == dst) begin
            res = cm;
        end else if (src == DEP_1) begin
            res = cm[0] ? depth_max(dst) : 8'd0;
        end else if (dst == DEP_1) begin
            res = (cm == depth_max(src)) ? 8'd1 : 8'd0;
        end else begin
            case ({src, dst})
                {DEP_5, DEP_6}: begin
                    prod = {22'd0, cm} * K_5_6;
                    res  = 8'(prod >> SH_FROM5);
                end
                {DEP_5, DEP_8}: begin
                    prod = {22'd0, cm} * K_5_8;
                    res  = 8'(prod >> SH_FROM5);
                end
                {DEP_6, DEP_5}: begin
                    prod = {22'd0, cm} * K_6_5;
                    res  = 8'(prod >> SH_FROM6);
                end
                {DEP_6, DEP_8}: begin
                    prod = {22'd0, cm} * K_6_8;
                    res  = 8'(prod >> SH_FROM6);
                end
                {DEP_8, DEP_5}: begin
                    prod = {22'd0, cm} * K_8_5;
                    res  = 8'(prod >> SH_FROM8);
                end
                {DEP_8, DEP_6}: begin
                    prod = {22'd0, cm} * K_8_6;
                    res  = 8'(prod >> SH_FROM8);
                end
                default: res = '0;
            endcase
        end
        return res;
    endfunction

endpackage

>>> sv/pfcb_blend_lane.sv
`timescale 1ns / 1ps

module pfcb_blend_lane
    import pfcb_pkg::*;
(
    input  logic       aclk,
    input  logic       en,
    input  chan_t      fore,
    input  chan_t      back,
    input  logic [7:0] alpha,
    output chan_t      blend
);

    logic [8:0]  fore_wt;
    logic [8:0]  back_wt;
    logic [16:0] fore_prod_next;
    logic [16:0] back_prod_next;
    logic [16:0] fore_prod_reg;
    logic [16:0] back_prod_reg;
    blend_sel_t  sel_next;
    blend_sel_t  sel_reg;
    chan_t       fore_reg;
    chan_t       back_reg;
    logic [17:0] mix_sum;
    chan_t       blend_next;
    chan_t       blend_reg;

    assign fore_wt        = {1'b0, alpha} + 9'd1;
    assign back_wt        = 9'd256 - {1'b0, alpha};
    assign fore_prod_next = {9'd0, fore} * {8'd0, fore_wt};
    assign back_prod_next = {9'd0, back} * {8'd0, back_wt};

    always_comb begin
        if (alpha == 8'd0) begin
            sel_next = BL_BACK;
        end else if (alpha == 8'hFF) begin
            sel_next = BL_FORE;
        end else begin
            sel_next = BL_MIX;
        end
    end

    assign mix_sum = {1'b0, fore_prod_reg} + {1'b0, back_prod_reg};

    always_comb begin
        case (sel_reg)
            BL_BACK: blend_next = back_reg;
            BL_FORE: blend_next = fore_reg;
            BL_MIX:  blend_next = mix_sum[15:8];
            default: blend_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fore_prod_reg <= fore_prod_next;
            back_prod_reg <= back_prod_next;
            sel_reg       <= sel_next;
            fore_reg      <= fore;
            back_reg      <= back;
            blend_reg     <= blend_next;
        end
    end

    assign blend = blend_reg;

endmodule

>>> sv/pixel_format_convert_blend.sv
`timescale 1ns / 1ps
// Pixel format converter and alpha blender.
// Input channel s_*: one request carries a foreground word, a background word and an
// 8-bit alpha. Output channel m_*: one blended word per request, in request order.
// Config channel cfg_*: index 0 foreground format, 1 background format, 2 output
// format (0 none, 1 mono, 2 rgb111, 3 rgb565, 4 rgb666, 5 rgb888; 6 and 7 act as none).
// cfg_ready is always high; write formats only while no request is in flight.
// Pipeline of four register stages: unpack and background rescale, blend products,
// blend sum and select, output rescale and pack into the output register.
// m_valid rises once a request has passed through stages 1 to 3 into the output register;
// one request per cycle is sustained while m_ready stays high.
// When m_ready is low with a result waiting, the whole pipeline holds and s_ready
// drops in the same cycle; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and sets all formats to rgb888.

`include "pixel_format_convert_blend_macros.svh"

module pixel_format_convert_blend
    import pfcb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_fore_word,
    input  logic [23:0] s_back_word,
    input  logic [7:0]  s_alpha,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_out_word
);

    logic [2:0] fore_format_reg;
    logic [2:0] back_format_reg;
    logic [2:0] out_format_reg;
    fmt_t       fore_fmt;
    fmt_t       back_fmt;
    fmt_t       out_fmt;

    logic       advance;
    logic       s1_valid_reg;
    logic       s2_valid_reg;
    logic       s3_valid_reg;
    logic       m_valid_reg;

    pix_t       fore_pix_next;
    pix_t       back_raw;
    pix_t       back_pix_next;
    pix_t       s1_fore_reg;
    pix_t       s1_back_reg;
    logic [7:0] s1_alpha_reg;
    pix_t       blend_pix;
    pix_t       out_pix;
    word_t      out_word_next;
    word_t      out_word_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fore_format_reg <= FMT_RGB888;
            back_format_reg <= FMT_RGB888;
            out_format_reg  <= FMT_RGB888;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FORE_FORMAT: fore_format_reg <= cfg_data;
                REG_BACK_FORMAT: back_format_reg <= cfg_data;
                REG_OUT_FORMAT:  out_format_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign fore_fmt = norm_fmt(fore_format_reg);
    assign back_fmt = norm_fmt(back_format_reg);
    assign out_fmt  = norm_fmt(out_format_reg);

    // pipeline control: all stages move together
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_valid_reg  <= s3_valid_reg;
        end
    end

    // stage 1: unpack, background to foreground depth
    always_comb begin
        fore_pix_next = unpack_pix(s_fore_word, fore_fmt);
        back_raw      = unpack_pix(s_back_word, back_fmt);
        for (int ch = 0; ch < 3; ch++) begin
            back_pix_next[ch] = rescale_chan(back_raw[ch], chan_depth(back_fmt, 2'(ch)),
                                             chan_depth(fore_fmt, 2'(ch)));
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_fore_reg  <= fore_pix_next;
            s1_back_reg  <= back_pix_next;
            s1_alpha_reg <= s_alpha;
        end
    end

    // stages 2 and 3: per-channel blend
    for (genvar g = 0; g < 3; g++) begin : g_lane
        pfcb_blend_lane u_lane (
            .aclk  (aclk),
            .en    (advance),
            .fore  (s1_fore_reg[g]),
            .back  (s1_back_reg[g]),
            .alpha (s1_alpha_reg),
            .blend (blend_pix[g])
        );
    end

    // stage 4: output depth and pack
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            out_pix[ch] = rescale_chan(blend_pix[ch], chan_depth(fore_fmt, 2'(ch)),
                                       chan_depth(out_fmt, 2'(ch)));
        end
        out_word_next = pack_pix(out_pix, out_fmt);
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_word = out_word_reg;

    `PFCB_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !s1_valid_reg && !s2_valid_reg && !s3_valid_reg && !m_valid_reg, "pipeline not empty after reset")
    `PFCB_ASSERT(a_ready_when_empty, !m_valid_reg |-> s_ready, "input stalled with output register empty")
    `PFCB_ASSERT(a_request_enters, s_valid && s_ready |=> s1_valid_reg, "accepted request lost at stage 1")
    `PFCB_ASSERT(a_stall_keeps_item, s3_valid_reg && !advance |=> s3_valid_reg, "request dropped during stall")

endmodule
